// File: rtl/dos_pkg.sv
// Shared types, codes and defaults for the depth obstacle steering unit.
`default_nettype none
package dos_pkg;

  localparam int unsigned DEF_MAX_WIDTH  = 1024;
  localparam int unsigned DEF_MAX_HEIGHT = 1024;

  localparam logic [10:0] RST_FRAME_WIDTH  = 11'd640;
  localparam logic [10:0] RST_FRAME_HEIGHT = 11'd480;
  localparam logic [15:0] RST_NEAR_MM      = 16'd2000;
  localparam logic [15:0] RST_CLEAR_MM     = 16'd2500;

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_NEAR_MM      = 2'd2,
    REG_CLEAR_MM     = 2'd3
  } reg_index_t;

  typedef enum logic [1:0] {
    CMD_STOP    = 2'd0,
    CMD_FORWARD = 2'd1,
    CMD_LEFT    = 2'd2,
    CMD_RIGHT   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_FWD  = 2'd1,
    MODE_TURN = 2'd2
  } mode_t;

  typedef struct packed {
    logic hit;
    logic side_right;
  } dos_scan_t;

  typedef struct packed {
    cmd_t command;
    logic seen;
    logic center_valid;
  } dos_verdict_t;

endpackage
`default_nettype wire

// File: rtl/dos_frame_scan.sv
// Per-frame pixel scan: counters, hit and extent search, row store and centre depth read.
`default_nettype none
module dos_frame_scan import dos_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        advance,
  input  wire logic [15:0] depth,
  input  wire logic        frame_end,
  input  wire logic [10:0] frame_width,
  input  wire logic [10:0] frame_height,
  input  wire logic [15:0] near_mm,
  input  wire logic [15:0] clear_mm,
  input  wire logic        mode_fwd,
  output dos_scan_t        scan,
  output logic [11:0]      x2_out,
  output logic [8:0]       row_out,
  output logic [15:0]      center_depth
);

  localparam int unsigned CW  = $clog2(MAX_WIDTH);
  localparam int unsigned RW  = $clog2(MAX_HEIGHT);
  localparam int unsigned WW0 = $clog2(MAX_WIDTH + 1);
  localparam int unsigned WW  = (WW0 > 11) ? WW0 : 11;
  localparam int unsigned HW0 = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned HW  = (HW0 > 11) ? HW0 : 11;

  logic [15:0]   row_store [MAX_WIDTH];

  logic [CW-1:0] column_count, column_count_next;
  logic [RW-1:0] row_count, row_count_next;
  logic          hit_found, hit_found_next;
  logic [CW-1:0] hit_column, hit_column_next;
  logic [RW-1:0] hit_row, hit_row_next;
  logic [WW-1:0] extent_column, extent_column_next;
  logic          extent_done, extent_done_next;

  logic [WW-1:0] w;
  logic [HW-1:0] h, half;
  logic [CW-1:0] col;
  logic          last_col;
  logic          store_we;
  logic [WW-1:0] ext;
  logic [WW:0]   x2;
  logic [CW-1:0] rd_addr;

  always_comb begin
    if (WW'(frame_width) == '0) begin
      w = WW'(1);
    end else if (WW'(frame_width) > WW'(MAX_WIDTH)) begin
      w = WW'(MAX_WIDTH);
    end else begin
      w = WW'(frame_width);
    end
    if (HW'(frame_height) > HW'(MAX_HEIGHT)) begin
      h = HW'(MAX_HEIGHT);
    end else begin
      h = HW'(frame_height);
    end
    half = h >> 1;
    if (WW'(column_count) >= w) begin
      col = CW'(w - WW'(1));
    end else begin
      col = column_count;
    end
    last_col = (WW'(col) == (w - WW'(1)));
    store_we = advance && (!hit_found || (row_count == hit_row));

    hit_found_next     = hit_found;
    hit_column_next    = hit_column;
    hit_row_next       = hit_row;
    extent_column_next = extent_column;
    extent_done_next   = extent_done;

    if (!hit_found) begin
      if ((HW'(row_count) < half) && (depth < near_mm)) begin
        hit_found_next  = 1'b1;
        hit_column_next = col;
        hit_row_next    = row_count;
      end
    end else if (mode_fwd && !extent_done &&
                 ((RW+1)'(row_count) == ((RW+1)'(hit_row) + (RW+1)'(1))) &&
                 (col >= hit_column)) begin
      if (depth > clear_mm) begin
        extent_column_next = WW'(col);
        extent_done_next   = 1'b1;
      end else if (last_col) begin
        extent_column_next = w;
        extent_done_next   = 1'b1;
      end
    end

    row_count_next = row_count;
    if (last_col) begin
      column_count_next = '0;
      if (HW'(row_count) < HW'(MAX_HEIGHT - 1)) begin
        row_count_next = row_count + RW'(1);
      end
    end else begin
      column_count_next = col + CW'(1);
    end

    ext     = extent_done_next ? extent_column_next : w;
    x2      = (WW+1)'(hit_column_next) + (WW+1)'(ext);
    rd_addr = x2[CW:1];

    scan.hit        = hit_found_next;
    scan.side_right = (x2 > (WW+1)'({w[WW-1:1], 1'b0}));
    x2_out          = 12'(x2);
    row_out         = 9'(hit_row_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count  <= '0;
      row_count     <= '0;
      hit_found     <= 1'b0;
      hit_column    <= '0;
      hit_row       <= '0;
      extent_column <= '0;
      extent_done   <= 1'b0;
    end else if (advance) begin
      if (frame_end) begin
        column_count  <= '0;
        row_count     <= '0;
        hit_found     <= 1'b0;
        hit_column    <= '0;
        hit_row       <= '0;
        extent_column <= '0;
        extent_done   <= 1'b0;
      end else begin
        column_count  <= column_count_next;
        row_count     <= row_count_next;
        hit_found     <= hit_found_next;
        hit_column    <= hit_column_next;
        hit_row       <= hit_row_next;
        extent_column <= extent_column_next;
        extent_done   <= extent_done_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      row_store[col] <= depth;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && frame_end) begin
      if (store_we && (col == rd_addr)) begin
        center_depth <= depth;
      end else begin
        center_depth <= row_store[rd_addr];
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/dos_mode_fsm.sv
// Steering mode machine: idle, forward and turn, one verdict per frame end.
`default_nettype none
module dos_mode_fsm import dos_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       frame_done,
  input  dos_scan_t       scan,
  output logic            mode_fwd,
  output dos_verdict_t    verdict
);

  mode_t mode, mode_next;
  logic  turn_right, turn_right_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_IDLE;
      turn_right <= 1'b0;
    end else if (frame_done) begin
      mode       <= mode_next;
      turn_right <= turn_right_next;
    end
  end

  always_comb begin
    mode_next            = mode;
    turn_right_next      = turn_right;
    verdict.command      = CMD_STOP;
    verdict.seen         = 1'b0;
    verdict.center_valid = 1'b0;
    mode_fwd             = (mode == MODE_FWD);
    case (mode)
      MODE_IDLE: begin
        mode_next = MODE_FWD;
      end
      MODE_FWD: begin
        verdict.seen = scan.hit;
        if (scan.hit) begin
          verdict.center_valid = 1'b1;
          turn_right_next      = scan.side_right;
          mode_next            = MODE_TURN;
        end else begin
          verdict.command = CMD_FORWARD;
        end
      end
      MODE_TURN: begin
        verdict.seen = scan.hit;
        if (scan.hit) begin
          verdict.command = turn_right ? CMD_RIGHT : CMD_LEFT;
        end else begin
          mode_next = MODE_FWD;
        end
      end
      default: begin
        mode_next = MODE_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/depth_obstacle_steering_unit.sv
// Top level of the depth obstacle steering unit: input register, config, result register.
//
// Usage:
//   Depth pixels enter in raster order on the input channel (in_valid/in_ready),
//   one beat per pixel, with frame_end set on the last pixel of a frame.
//   Exactly one result beat leaves on the output channel (out_valid/out_ready)
//   per frame_end pixel; other pixels give no result. The first frame after
//   reset only arms the mode machine and reports stop.
//   Throughput: one pixel per cycle, except while a frame_end pixel waits on a
//   stalled result. A pixel is held in the input register; the result of a
//   frame_end pixel is written to the result register as that pixel leaves.
//   The path is set by the hit and extent compare and the row store address
//   add between those two registers; the row store is read at that same edge.
//   While a result waits on out_ready, ordinary pixels keep flowing; only a
//   second frame_end pixel holds in the input register and drops in_ready.
//   Configuration is written through cfg_write_en/cfg_index/cfg_data while
//   no pixel is in flight. Reset restores default registers, idle mode and
//   clears all frame counters; the row store is not cleared.
`default_nettype none
module depth_obstacle_steering_unit import dos_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write_en,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [15:0] depth_mm,
  input  wire logic        frame_end,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       command,
  output logic             obstacle_seen,
  output logic             center_valid,
  output logic [11:0]      center_column_x2,
  output logic [8:0]       center_row,
  output logic [15:0]      center_depth_mm
);

  logic [10:0]  frame_width, frame_height;
  logic [15:0]  near_mm, clear_mm;

  logic         in_full;
  logic [15:0]  in_depth;
  logic         in_end;
  logic         advance;
  logic         frame_done;

  dos_scan_t    scan;
  dos_verdict_t verdict;
  logic         mode_fwd;
  logic [11:0]  x2;
  logic [8:0]   row;
  logic [15:0]  depth_rd;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= RST_FRAME_WIDTH;
      frame_height <= RST_FRAME_HEIGHT;
      near_mm      <= RST_NEAR_MM;
      clear_mm     <= RST_CLEAR_MM;
    end else if (cfg_write_en) begin
      case (reg_index_t'(cfg_index))
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[10:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[10:0];
        REG_NEAR_MM:      near_mm      <= cfg_data;
        REG_CLEAR_MM:     clear_mm     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign advance    = in_full && (!in_end || !out_valid || out_ready);
  assign frame_done = advance && in_end;
  assign in_ready   = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_depth <= depth_mm;
      in_end   <= frame_end;
    end
  end

  dos_frame_scan #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_scan (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .depth        (in_depth),
    .frame_end    (in_end),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .near_mm      (near_mm),
    .clear_mm     (clear_mm),
    .mode_fwd     (mode_fwd),
    .scan         (scan),
    .x2_out       (x2),
    .row_out      (row),
    .center_depth (depth_rd)
  );

  dos_mode_fsm u_mode (
    .clk        (clk),
    .rst        (rst),
    .frame_done (frame_done),
    .scan       (scan),
    .mode_fwd   (mode_fwd),
    .verdict    (verdict)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (frame_done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_done) begin
      command          <= verdict.command;
      obstacle_seen    <= verdict.seen;
      center_valid     <= verdict.center_valid;
      center_column_x2 <= verdict.center_valid ? x2 : 12'd0;
      center_row       <= verdict.center_valid ? row : 9'd0;
    end
  end

  assign center_depth_mm = center_valid ? depth_rd : 16'd0;

  a_center_means_stop: assert property (@(posedge clk) disable iff (rst)
    out_valid && center_valid |-> (command == CMD_STOP) && obstacle_seen)
    else $error("centre report without stop and obstacle");

  a_turn_needs_obstacle: assert property (@(posedge clk) disable iff (rst)
    out_valid && !obstacle_seen |-> (command == CMD_STOP) || (command == CMD_FORWARD))
    else $error("turn command without obstacle");

  a_end_holds_on_stall: assert property (@(posedge clk) disable iff (rst)
    in_full && in_end && out_valid && !out_ready |-> !in_ready && !advance)
    else $error("frame end advanced over a stalled result");

  a_result_from_frame_end: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_full && in_end))
    else $error("result raised without a frame end pixel");

endmodule
`default_nettype wire
